### src/userpass_auth_parse_match_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the username/password authentication block
// Concurrent assertions clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef USERPASS_AUTH_PARSE_MATCH_ASSERT_SVH
`define USERPASS_AUTH_PARSE_MATCH_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define UPAM_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("userpass_auth_parse_match: assertion failed");
`define UPAM_ASSERT(lbl, prop) `UPAM_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define UPAM_ASSERT_CLK(lbl, clk, rst_n, prop)
`define UPAM_ASSERT(lbl, prop)
`endif

`endif

### src/upam_pkg.sv
// ---------------------------------------------------------------------------
// Username/password authentication package
// Shared codes, constants and types of the authentication parser.
// ---------------------------------------------------------------------------
package upam_pkg;

  localparam int DEF_USER_SLOTS       = 8;
  localparam int DEF_CREDENTIAL_BYTES = 255;

  localparam logic [7:0] VERSION_BYTE = 8'h01;
  localparam logic [7:0] STATUS_OK    = 8'h00;
  localparam logic [7:0] STATUS_FAIL  = 8'hFF;
  localparam logic [7:0] ZERO_BYTE    = 8'h00;

  localparam logic FIELD_NAME = 1'b0;

  typedef enum logic [1:0] {
    OP_STREAM  = 2'd0,
    OP_LOAD    = 2'd1,
    OP_SET_LEN = 2'd2,
    OP_START   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_VERSION  = 3'd0,
    PH_NAME_LEN = 3'd1,
    PH_NAME     = 3'd2,
    PH_PASS_LEN = 3'd3,
    PH_PASS     = 3'd4,
    PH_FINISHED = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    K_NONE      = 3'd0,
    K_START     = 3'd1,
    K_NAME_LEN  = 3'd2,
    K_NAME_BYTE = 3'd3,
    K_PASS_LEN  = 3'd4,
    K_PASS_BYTE = 3'd5,
    K_FAIL      = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] pos;
    logic       reply;
  } s1_t;

  typedef struct packed {
    logic       valid;
    logic       granted;
    logic [2:0] slot;
  } rep_t;

endpackage

### src/userpass_auth_parse_match.sv
// ---------------------------------------------------------------------------
// Username/password authentication parser and matcher
// Parses a sub-negotiation byte stream and checks it against a loaded
// credential table, answering with a two-beat reply.
// ---------------------------------------------------------------------------
// Usage: every input beat carries an operation. Load and set-length beats
// fill the credential table, start-session beats open a new message, and
// stream beats carry the received bytes in order.
// A beat that completes or breaks a message yields two output beats: 0x01,
// then the status byte with reply_last_o set, granted_o and matched_slot_o.
// Input beats are taken one per cycle while in_ready_o is high. The byte
// comparison works on the input register against per-slot credential
// RAMs read at the current byte position. A reply passes the input
// register and the reply queue; the status beat follows the 0x01 beat.
// Pending replies wait in a two-entry queue; while the receiver stalls,
// input is taken until the queue and the stage ahead of it hold two
// replies, then in_ready_o drops.
// Reset empties the length table, so all slots read as empty, and sets the
// parser to expect the version byte. Credential bytes are not cleared.
// ---------------------------------------------------------------------------
`include "userpass_auth_parse_match_assert.svh"

module userpass_auth_parse_match #(
  parameter int USER_SLOTS       = upam_pkg::DEF_USER_SLOTS,
  parameter int CREDENTIAL_BYTES = upam_pkg::DEF_CREDENTIAL_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] data_byte_i,
  input  logic [2:0] user_slot_i,
  input  logic       which_field_i,
  input  logic [7:0] position_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] reply_byte_o,
  output logic       reply_last_o,
  output logic       granted_o,
  output logic [2:0] matched_slot_o
);

  localparam int AddrW = (CREDENTIAL_BYTES > 1) ? $clog2(CREDENTIAL_BYTES) : 1;

  upam_pkg::phase_e phase_q, phase_d;
  logic [7:0]       name_seen_q, name_seen_d;
  logic [7:0]       pass_seen_q, pass_seen_d;
  logic [7:0]       count_q, count_d;
  logic [7:0]       count_inc;
  upam_pkg::s1_t    s1_q, s1_d;
  logic             s1_valid_q;
  upam_pkg::op_e    op;
  logic             accept;
  logic             slot_ok;
  logic             pos_ok;
  logic [7:0]       sat_len;

  logic [7:0]       name_len_q   [USER_SLOTS];
  logic [7:0]       pass_len_q   [USER_SLOTS];
  logic [7:0]       name_rdata   [USER_SLOTS];
  logic [7:0]       pass_rdata   [USER_SLOTS];

  upam_pkg::rep_t   rep;
  logic             fifo_granted_q [2];
  logic [2:0]       fifo_slot_q    [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       fill_q;
  logic             beat_q;
  logic             push, pop;

  assign op        = upam_pkg::op_e'(operation_i);
  assign accept    = in_valid_i && in_ready_o;
  assign slot_ok   = int'(user_slot_i) < USER_SLOTS;
  assign pos_ok    = int'(position_i) < CREDENTIAL_BYTES;
  assign sat_len   = (int'(data_byte_i) > CREDENTIAL_BYTES) ? 8'(CREDENTIAL_BYTES)
                                                            : data_byte_i;
  assign count_inc = count_q + 8'd1;

  assign in_ready_o = (fill_q == 2'd0) || (fill_q == 2'd1 && !(s1_valid_q && s1_q.reply));

  always_comb begin
    phase_d     = phase_q;
    name_seen_d = name_seen_q;
    pass_seen_d = pass_seen_q;
    count_d     = count_q;
    s1_d.kind   = upam_pkg::K_NONE;
    s1_d.data   = data_byte_i;
    s1_d.pos    = count_q;
    s1_d.reply  = 1'b0;
    if (accept) begin
      unique case (op)
        upam_pkg::OP_START: begin
          phase_d     = upam_pkg::PH_VERSION;
          name_seen_d = 8'd0;
          pass_seen_d = 8'd0;
          count_d     = 8'd0;
          s1_d.kind   = upam_pkg::K_START;
        end
        upam_pkg::OP_LOAD, upam_pkg::OP_SET_LEN: begin
          s1_d.kind = upam_pkg::K_NONE;
        end
        upam_pkg::OP_STREAM: begin
          unique case (phase_q)
            upam_pkg::PH_VERSION: begin
              if (data_byte_i != upam_pkg::VERSION_BYTE) begin
                phase_d    = upam_pkg::PH_FINISHED;
                s1_d.kind  = upam_pkg::K_FAIL;
                s1_d.reply = 1'b1;
              end else begin
                phase_d = upam_pkg::PH_NAME_LEN;
              end
            end
            upam_pkg::PH_NAME_LEN: begin
              if (data_byte_i == upam_pkg::ZERO_BYTE) begin
                phase_d    = upam_pkg::PH_FINISHED;
                s1_d.kind  = upam_pkg::K_FAIL;
                s1_d.reply = 1'b1;
              end else begin
                name_seen_d = data_byte_i;
                count_d     = 8'd0;
                s1_d.kind   = upam_pkg::K_NAME_LEN;
                phase_d     = upam_pkg::PH_NAME;
              end
            end
            upam_pkg::PH_NAME: begin
              s1_d.kind = upam_pkg::K_NAME_BYTE;
              count_d   = count_inc;
              if (count_inc >= name_seen_q) phase_d = upam_pkg::PH_PASS_LEN;
            end
            upam_pkg::PH_PASS_LEN: begin
              if (data_byte_i == upam_pkg::ZERO_BYTE) begin
                phase_d    = upam_pkg::PH_FINISHED;
                s1_d.kind  = upam_pkg::K_FAIL;
                s1_d.reply = 1'b1;
              end else begin
                pass_seen_d = data_byte_i;
                count_d     = 8'd0;
                s1_d.kind   = upam_pkg::K_PASS_LEN;
                phase_d     = upam_pkg::PH_PASS;
              end
            end
            upam_pkg::PH_PASS: begin
              s1_d.kind = upam_pkg::K_PASS_BYTE;
              count_d   = count_inc;
              if (count_inc >= pass_seen_q) begin
                phase_d    = upam_pkg::PH_FINISHED;
                s1_d.reply = 1'b1;
              end
            end
            default: phase_d = phase_q;
          endcase
        end
        default: s1_d.kind = upam_pkg::K_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= upam_pkg::PH_VERSION;
      name_seen_q <= 8'd0;
      pass_seen_q <= 8'd0;
      count_q     <= 8'd0;
      s1_valid_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      name_seen_q <= name_seen_d;
      pass_seen_q <= pass_seen_d;
      count_q     <= count_d;
      s1_valid_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  for (genvar s = 0; s < USER_SLOTS; s++) begin : g_slot
    logic wr_slot;
    assign wr_slot = accept && slot_ok && (int'(user_slot_i) == s);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        name_len_q[s] <= 8'd0;
        pass_len_q[s] <= 8'd0;
      end else if (wr_slot && op == upam_pkg::OP_SET_LEN) begin
        if (which_field_i == upam_pkg::FIELD_NAME) begin
          name_len_q[s] <= sat_len;
        end else begin
          pass_len_q[s] <= sat_len;
        end
      end
    end

    upam_ram #(
      .WIDTH (8),
      .DEPTH (CREDENTIAL_BYTES)
    ) u_name_ram (
      .clk_i   (clk_i),
      .we_i    (wr_slot && pos_ok && op == upam_pkg::OP_LOAD &&
                which_field_i == upam_pkg::FIELD_NAME),
      .waddr_i (position_i[AddrW-1:0]),
      .wdata_i (data_byte_i),
      .raddr_i (count_q[AddrW-1:0]),
      .rdata_o (name_rdata[s])
    );

    upam_ram #(
      .WIDTH (8),
      .DEPTH (CREDENTIAL_BYTES)
    ) u_pass_ram (
      .clk_i   (clk_i),
      .we_i    (wr_slot && pos_ok && op == upam_pkg::OP_LOAD &&
                which_field_i != upam_pkg::FIELD_NAME),
      .waddr_i (position_i[AddrW-1:0]),
      .wdata_i (data_byte_i),
      .raddr_i (count_q[AddrW-1:0]),
      .rdata_o (pass_rdata[s])
    );
  end

  upam_match #(
    .USER_SLOTS (USER_SLOTS)
  ) u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid_q),
    .s1_i         (s1_q),
    .name_rdata_i (name_rdata),
    .pass_rdata_i (pass_rdata),
    .name_len_i   (name_len_q),
    .pass_len_i   (pass_len_q),
    .rep_o        (rep)
  );

  assign push = rep.valid;
  assign pop  = out_valid_o && out_ready_i && beat_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_granted_q[wptr_q] <= rep.granted;
      fifo_slot_q[wptr_q]    <= rep.slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
      beat_q <= 1'b0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
      if (out_valid_o && out_ready_i) beat_q <= ~beat_q;
    end
  end

  assign out_valid_o    = fill_q != 2'd0;
  assign reply_last_o   = beat_q;
  assign granted_o      = beat_q && fifo_granted_q[rptr_q];
  assign matched_slot_o = granted_o ? fifo_slot_q[rptr_q] : 3'd0;
  assign reply_byte_o   = !beat_q ? upam_pkg::VERSION_BYTE :
                          fifo_granted_q[rptr_q] ? upam_pkg::STATUS_OK : upam_pkg::STATUS_FAIL;

  `UPAM_ASSERT(a_fill_bound, fill_q != 2'd3)
  `UPAM_ASSERT(a_no_overflow, rep.valid |-> fill_q != 2'd2)
  `UPAM_ASSERT(a_granted_status, granted_o |-> reply_last_o && reply_byte_o == upam_pkg::STATUS_OK)
  `UPAM_ASSERT(a_beat_idle, !out_valid_o |-> !beat_q)

endmodule

### src/upam_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module upam_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/upam_match.sv
// ---------------------------------------------------------------------------
// Credential match stage
// Keeps one match bit per slot, sets them all on session start, clears
// bits on mismatching beats and decides the outcome when a reply is due.
// ---------------------------------------------------------------------------
module upam_match #(
  parameter int USER_SLOTS = upam_pkg::DEF_USER_SLOTS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s1_valid_i,
  input  upam_pkg::s1_t   s1_i,
  input  logic [7:0]      name_rdata_i [USER_SLOTS],
  input  logic [7:0]      pass_rdata_i [USER_SLOTS],
  input  logic [7:0]      name_len_i   [USER_SLOTS],
  input  logic [7:0]      pass_len_i   [USER_SLOTS],
  output upam_pkg::rep_t  rep_o
);

  logic [USER_SLOTS-1:0] match_q;
  logic [USER_SLOTS-1:0] match_d;
  logic                  found;
  logic                  stop;
  logic [2:0]            found_slot;

  always_comb begin
    match_d = match_q;
    if (s1_valid_i) begin
      unique case (s1_i.kind)
        upam_pkg::K_START: match_d = '1;
        upam_pkg::K_NAME_LEN: begin
          for (int s = 0; s < USER_SLOTS; s++) begin
            if (name_len_i[s] != s1_i.data) match_d[s] = 1'b0;
          end
        end
        upam_pkg::K_PASS_LEN: begin
          for (int s = 0; s < USER_SLOTS; s++) begin
            if (pass_len_i[s] != s1_i.data) match_d[s] = 1'b0;
          end
        end
        upam_pkg::K_NAME_BYTE: begin
          for (int s = 0; s < USER_SLOTS; s++) begin
            if (s1_i.data == upam_pkg::ZERO_BYTE || s1_i.pos >= name_len_i[s] ||
                name_rdata_i[s] != s1_i.data) begin
              match_d[s] = 1'b0;
            end
          end
        end
        upam_pkg::K_PASS_BYTE: begin
          for (int s = 0; s < USER_SLOTS; s++) begin
            if (s1_i.data == upam_pkg::ZERO_BYTE || s1_i.pos >= pass_len_i[s] ||
                pass_rdata_i[s] != s1_i.data) begin
              match_d[s] = 1'b0;
            end
          end
        end
        default: match_d = match_q;
      endcase
    end
  end

  // Only slots before the first empty name take part; the lowest match wins.
  always_comb begin
    found      = 1'b0;
    stop       = 1'b0;
    found_slot = 3'd0;
    for (int s = 0; s < USER_SLOTS; s++) begin
      if (name_len_i[s] == upam_pkg::ZERO_BYTE) stop = 1'b1;
      if (!stop && !found && match_d[s]) begin
        found      = 1'b1;
        found_slot = 3'(s);
      end
    end
  end

  always_comb begin
    rep_o.valid   = s1_valid_i && s1_i.reply;
    rep_o.granted = (s1_i.kind == upam_pkg::K_PASS_BYTE) && found;
    rep_o.slot    = rep_o.granted ? found_slot : 3'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '1;
    end else begin
      match_q <= match_d;
    end
  end

endmodule
